// ===== hw/rtl/clfe_pkg.sv =====
// shared types and constants for the clipped line frame store engine
`timescale 1ns / 1ps
`default_nettype none
package clfe_pkg;

  // command codes
  localparam logic [2:0] CMD_PIXEL  = 3'd0;
  localparam logic [2:0] CMD_LINE   = 3'd1;
  localparam logic [2:0] CMD_RDPIX  = 3'd2;
  localparam logic [2:0] CMD_RDBYTE = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  // draw modes
  localparam logic [1:0] MODE_SET = 2'd0;
  localparam logic [1:0] MODE_CLR = 2'd1;
  localparam logic [1:0] MODE_INV = 2'd2;

  // outcode bits
  localparam logic [3:0] OC_LEFT   = 4'd1;
  localparam logic [3:0] OC_RIGHT  = 4'd2;
  localparam logic [3:0] OC_BOTTOM = 4'd4;
  localparam logic [3:0] OC_TOP    = 4'd8;

  // clip coordinate and product widths
  localparam int CW = 18;
  localparam int PW = 2 * CW;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_PIXEL,
    OP_LINE,
    OP_RDPIX,
    OP_RDBYTE,
    OP_CLEAR
  } op_t;

  // classified command word held in the queue
  typedef struct packed {
    op_t                op;
    logic               pix_on;
    logic               addr_ok;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [15:0] ex;
    logic signed [15:0] ey;
    logic [1:0]         mode;
    logic [9:0]         addr;
  } item_t;

  // back end status seen by the front end
  typedef struct packed {
    logic pop;
    logic init_clr;
  } back_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/clipped_line_framebuffer_engine.sv =====
// top level of the clipped line frame store engine
// words that leave the store alone are answered from idle, one per cycle while the queue
//   holds words; pixel and read words read the store in idle, then write in S_PIX_WR or
//   answer from an output state; a line runs the clip states per clip edge, then a read
//   and a write state per drawn pixel; a clear sweeps every store byte; results are registered
//   and the receiver cannot stall them; reset: synchronous active-low, busy stays high while the store clears
`timescale 1ns / 1ps
`default_nettype none
module clipped_line_framebuffer_engine #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         in_command,
  input  wire logic signed [15:0] in_start_x,
  input  wire logic signed [15:0] in_start_y,
  input  wire logic signed [15:0] in_end_x,
  input  wire logic signed [15:0] in_end_y,
  input  wire logic [1:0]         in_draw_mode,
  input  wire logic [9:0]         in_byte_address,
  output logic                    out_valid,
  output logic [7:0]              out_read_byte,
  output logic                    out_pixel_set,
  output logic                    out_line_shown
);
  import clfe_pkg::*;

  // classified word at the queue head
  item_t      q_item;
  logic       q_valid;
  // pop and init-clear status from the executor
  back_stat_t bstat;

  // front: takes words, flags on-screen pixels and in-range addresses
  clfe_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_end_x        (in_end_x),
    .in_end_y        (in_end_y),
    .in_draw_mode    (in_draw_mode),
    .in_byte_address (in_byte_address),
    .q_item          (q_item),
    .q_valid         (q_valid),
    .bstat           (bstat)
  );

  // back: store access, clipping, line stepping, one result per word
  clfe_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_item         (q_item),
    .q_valid        (q_valid),
    .bstat          (bstat),
    .out_valid      (out_valid),
    .out_read_byte  (out_read_byte),
    .out_pixel_set  (out_pixel_set),
    .out_line_shown (out_line_shown)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/clfe_front.sv =====
// command intake, classification and two-entry queue
`timescale 1ns / 1ps
`default_nettype none
module clfe_front #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         in_command,
  input  wire logic signed [15:0] in_start_x,
  input  wire logic signed [15:0] in_start_y,
  input  wire logic signed [15:0] in_end_x,
  input  wire logic signed [15:0] in_end_y,
  input  wire logic [1:0]         in_draw_mode,
  input  wire logic [9:0]         in_byte_address,
  output clfe_pkg::item_t         q_item,
  output logic                    q_valid,
  input  wire clfe_pkg::back_stat_t bstat
);
  import clfe_pkg::*;

  localparam int STORE_BYTES = SCREEN_WIDTH * ((SCREEN_HEIGHT + 7) / 8);

  item_t      q_mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;
  item_t      cls;

  assign busy    = (cnt_r == 2'd2) || bstat.init_clr;
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign pop     = bstat.pop && q_valid;
  assign q_item  = q_mem_r[rp_r];

  always_comb begin
    cls.sx      = in_start_x;
    cls.sy      = in_start_y;
    cls.ex      = in_end_x;
    cls.ey      = in_end_y;
    cls.mode    = in_draw_mode;
    cls.addr    = in_byte_address;
    cls.pix_on  = !in_start_x[15] && !in_start_y[15] &&
                  (32'(in_start_x) < 32'(SCREEN_WIDTH)) &&
                  (32'(in_start_y) < 32'(SCREEN_HEIGHT));
    cls.addr_ok = 32'(in_byte_address) < 32'(STORE_BYTES);
    case (in_command)
      CMD_PIXEL:  cls.op = OP_PIXEL;
      CMD_LINE:   cls.op = OP_LINE;
      CMD_RDPIX:  cls.op = OP_RDPIX;
      CMD_RDBYTE: cls.op = OP_RDBYTE;
      CMD_CLEAR:  cls.op = OP_CLEAR;
      default:    cls.op = OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wp_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/clfe_div.sv =====
// bit-serial signed divider, quotient truncated toward zero
`timescale 1ns / 1ps
`default_nettype none
module clfe_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic signed [clfe_pkg::PW-1:0] dividend,
  input  wire logic signed [clfe_pkg::CW-1:0] divisor,
  output logic                               done,
  output logic signed [clfe_pkg::CW-1:0]     quotient
);
  import clfe_pkg::*;

  localparam int NW = $clog2(PW + 1);

  logic [PW-1:0] n_r;
  logic [CW-1:0] rem_r, d_r;
  logic [NW-1:0] cnt_r;
  logic          run_r, neg_r, done_r;
  logic [CW:0]   sh;
  logic          ge;

  assign sh       = {rem_r, n_r[PW-1]};
  assign ge       = sh >= {1'b0, d_r};
  assign done     = done_r;
  assign quotient = neg_r ? -$signed(n_r[CW-1:0]) : $signed(n_r[CW-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        n_r   <= dividend[PW-1] ? PW'(-dividend) : PW'(dividend);
        d_r   <= divisor[CW-1] ? CW'(-divisor) : CW'(divisor);
        rem_r <= '0;
        cnt_r <= NW'(PW);
        neg_r <= dividend[PW-1] ^ divisor[CW-1];
        run_r <= 1'b1;
      end else if (run_r) begin
        rem_r <= ge ? CW'(sh - {1'b0, d_r}) : sh[CW-1:0];
        n_r   <= {n_r[PW-2:0], ge};
        cnt_r <= cnt_r - NW'(1);
        if (cnt_r == NW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/clfe_back.sv =====
// command execution: frame store, clipper, line stepper and results
`timescale 1ns / 1ps
`default_nettype none
module clfe_back #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire clfe_pkg::item_t q_item,
  input  wire logic            q_valid,
  output clfe_pkg::back_stat_t bstat,
  output logic                 out_valid,
  output logic [7:0]           out_read_byte,
  output logic                 out_pixel_set,
  output logic                 out_line_shown
);
  import clfe_pkg::*;

  localparam int STORE_BYTES = SCREEN_WIDTH * ((SCREEN_HEIGHT + 7) / 8);
  localparam int AW = $clog2(STORE_BYTES);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_PIX_WR, S_RDPIX_OUT, S_RDB_OUT, S_CLR,
    S_CL_TEST, S_CL_MUL, S_CL_DSTART, S_CL_DIV,
    S_BR_SET, S_BR_RD, S_BR_WR
  } state_t;

  logic [7:0] mem [STORE_BYTES];
  logic [7:0] mem_q;

  state_t                state_r, state_nxt;
  logic [1:0]            mode_r, mode_nxt;
  logic [2:0]            bsel_r, bsel_nxt;
  logic [AW-1:0]         idx_r, idx_nxt;
  logic [AW-1:0]         clr_r, clr_nxt;
  logic signed [CW-1:0]  x0_r, y0_r, x1_r, y1_r;
  logic signed [CW-1:0]  x0_nxt, y0_nxt, x1_nxt, y1_nxt;
  logic [5:0]            guard_r, guard_nxt;
  logic signed [CW-1:0]  mula_r, mulb_r, den_r, fix_r;
  logic signed [CW-1:0]  mula_nxt, mulb_nxt, den_nxt, fix_nxt;
  logic                  vert_r, vert_nxt, end0_r, end0_nxt;
  logic signed [PW-1:0]  prod_r, prod_nxt;
  logic [8:0]            bx_r, by_r, bx1_r, dmaj_r, dmin_r;
  logic [8:0]            bx_nxt, by_nxt, bx1_nxt, dmaj_nxt, dmin_nxt;
  logic signed [9:0]     err_r, err_nxt;
  logic                  steep_r, steep_nxt, yneg_r, yneg_nxt;
  logic                  ov_r, ov_nxt, ops_r, ops_nxt, ols_r, ols_nxt;
  logic [7:0]            orb_r, orb_nxt;

  logic                  rd_en, wr_en;
  logic [AW-1:0]         rd_addr, wr_addr;
  logic [7:0]            wr_data;
  logic                  div_start, div_done;
  logic signed [CW-1:0]  div_q;

  // clip and stepping temporaries
  logic [3:0]            c0, c1, co;
  logic signed [CW-1:0]  dx, dy, nx, ny;
  logic [8:0]            a0, b0, a1, b1, adx, ady;
  logic                  stp;
  logic signed [9:0]     e1;
  logic [7:0]            px, py;

  function automatic logic [3:0] oc(input logic signed [CW-1:0] x,
                                    input logic signed [CW-1:0] y);
    logic [3:0] c;
    c = 4'd0;
    if (x < 0) begin
      c = c | OC_LEFT;
    end else if (x >= CW'(SCREEN_WIDTH)) begin
      c = c | OC_RIGHT;
    end
    if (y < 0) begin
      c = c | OC_TOP;
    end else if (y >= CW'(SCREEN_HEIGHT)) begin
      c = c | OC_BOTTOM;
    end
    return c;
  endfunction

  function automatic logic [AW-1:0] pidx(input logic [7:0] x, input logic [7:0] y);
    return AW'(x) + AW'(y >> 3) * AW'(SCREEN_WIDTH);
  endfunction

  function automatic logic [7:0] modb(input logic [7:0] b, input logic [2:0] s,
                                      input logic [1:0] m);
    logic [7:0] bit_m;
    bit_m = 8'd1 << s;
    case (m)
      MODE_SET: return b | bit_m;
      MODE_CLR: return b & ~bit_m;
      MODE_INV: return b ^ bit_m;
      default:  return b;
    endcase
  endfunction

  clfe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (den_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign bstat.pop      = (state_r == S_IDLE) && q_valid;
  assign bstat.init_clr = (state_r == S_INIT);

  assign out_valid      = ov_r;
  assign out_read_byte  = orb_r;
  assign out_pixel_set  = ops_r;
  assign out_line_shown = ols_r;

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    bsel_nxt  = bsel_r;
    idx_nxt   = idx_r;
    clr_nxt   = clr_r;
    x0_nxt    = x0_r;
    y0_nxt    = y0_r;
    x1_nxt    = x1_r;
    y1_nxt    = y1_r;
    guard_nxt = guard_r;
    mula_nxt  = mula_r;
    mulb_nxt  = mulb_r;
    den_nxt   = den_r;
    fix_nxt   = fix_r;
    vert_nxt  = vert_r;
    end0_nxt  = end0_r;
    prod_nxt  = prod_r;
    bx_nxt    = bx_r;
    by_nxt    = by_r;
    bx1_nxt   = bx1_r;
    dmaj_nxt  = dmaj_r;
    dmin_nxt  = dmin_r;
    err_nxt   = err_r;
    steep_nxt = steep_r;
    yneg_nxt  = yneg_r;
    ov_nxt    = 1'b0;
    orb_nxt   = 8'd0;
    ops_nxt   = 1'b0;
    ols_nxt   = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = idx_r;
    wr_data   = modb(mem_q, bsel_r, mode_r);
    div_start = 1'b0;

    c0  = oc(x0_r, y0_r);
    c1  = oc(x1_r, y1_r);
    co  = (c0 != 4'd0) ? c0 : c1;
    dx  = x1_r - x0_r;
    dy  = y1_r - y0_r;
    nx  = vert_r ? x0_r + div_q : fix_r;
    ny  = vert_r ? fix_r : y0_r + div_q;
    adx = (x1_r[8:0] > x0_r[8:0]) ? x1_r[8:0] - x0_r[8:0] : x0_r[8:0] - x1_r[8:0];
    ady = (y1_r[8:0] > y0_r[8:0]) ? y1_r[8:0] - y0_r[8:0] : y0_r[8:0] - y1_r[8:0];
    stp = ady > adx;
    a0  = stp ? y0_r[8:0] : x0_r[8:0];
    b0  = stp ? x0_r[8:0] : y0_r[8:0];
    a1  = stp ? y1_r[8:0] : x1_r[8:0];
    b1  = stp ? x1_r[8:0] : y1_r[8:0];
    e1  = err_r - $signed({1'b0, dmin_r});
    px  = steep_r ? by_r[7:0] : bx_r[7:0];
    py  = steep_r ? bx_r[7:0] : by_r[7:0];

    case (state_r)
      S_INIT, S_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = 8'd0;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(STORE_BYTES - 1)) begin
          state_nxt = S_IDLE;
          ov_nxt    = (state_r == S_CLR);
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          mode_nxt = q_item.mode;
          bsel_nxt = q_item.sy[2:0];
          idx_nxt  = pidx(q_item.sx[7:0], q_item.sy[7:0]);
          case (q_item.op)
            OP_PIXEL: begin
              if (q_item.pix_on && q_item.mode != 2'd3) begin
                rd_en     = 1'b1;
                rd_addr   = idx_nxt;
                state_nxt = S_PIX_WR;
              end else begin
                ov_nxt = 1'b1;
              end
            end
            OP_RDPIX: begin
              if (q_item.pix_on) begin
                rd_en     = 1'b1;
                rd_addr   = idx_nxt;
                state_nxt = S_RDPIX_OUT;
              end else begin
                ov_nxt = 1'b1;
              end
            end
            OP_RDBYTE: begin
              if (q_item.addr_ok) begin
                rd_en     = 1'b1;
                rd_addr   = AW'(q_item.addr);
                state_nxt = S_RDB_OUT;
              end else begin
                ov_nxt = 1'b1;
              end
            end
            OP_CLEAR: begin
              clr_nxt   = '0;
              state_nxt = S_CLR;
            end
            OP_LINE: begin
              x0_nxt    = CW'(q_item.sx);
              y0_nxt    = CW'(q_item.sy);
              x1_nxt    = CW'(q_item.ex);
              y1_nxt    = CW'(q_item.ey);
              guard_nxt = 6'd0;
              state_nxt = S_CL_TEST;
            end
            default: begin
              ov_nxt = 1'b1;
            end
          endcase
        end
      end
      S_PIX_WR: begin
        wr_en     = 1'b1;
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
      end
      S_RDPIX_OUT: begin
        ov_nxt    = 1'b1;
        ops_nxt   = mem_q[bsel_r];
        state_nxt = S_IDLE;
      end
      S_RDB_OUT: begin
        ov_nxt    = 1'b1;
        orb_nxt   = mem_q;
        state_nxt = S_IDLE;
      end
      S_CL_TEST: begin
        end0_nxt = (c0 != 4'd0);
        vert_nxt = (co & (OC_BOTTOM | OC_TOP)) != 4'd0;
        if (vert_nxt) begin
          fix_nxt  = ((co & OC_BOTTOM) != 4'd0) ? CW'(SCREEN_HEIGHT - 1) : '0;
          mula_nxt = dx;
          mulb_nxt = fix_nxt - y0_r;
          den_nxt  = dy;
        end else begin
          fix_nxt  = ((co & OC_RIGHT) != 4'd0) ? CW'(SCREEN_WIDTH - 1) : '0;
          mula_nxt = dy;
          mulb_nxt = fix_nxt - x0_r;
          den_nxt  = dx;
        end
        if (guard_r == 6'd32) begin
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end else if ((c0 | c1) == 4'd0) begin
          state_nxt = S_BR_SET;
        end else if ((c0 & c1) != 4'd0 || den_nxt == '0) begin
          // trivially outside, or parallel to the edge
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_CL_MUL;
        end
      end
      S_CL_MUL: begin
        prod_nxt  = mula_r * mulb_r;
        state_nxt = S_CL_DSTART;
      end
      S_CL_DSTART: begin
        div_start = 1'b1;
        state_nxt = S_CL_DIV;
      end
      S_CL_DIV: begin
        if (div_done) begin
          if (end0_r) begin
            x0_nxt = nx;
            y0_nxt = ny;
          end else begin
            x1_nxt = nx;
            y1_nxt = ny;
          end
          guard_nxt = guard_r + 6'd1;
          state_nxt = S_CL_TEST;
        end
      end
      S_BR_SET: begin
        steep_nxt = stp;
        if (a0 > a1) begin
          bx_nxt  = a1;
          by_nxt  = b1;
          bx1_nxt = a0;
          dmaj_nxt = a0 - a1;
          yneg_nxt = !(b1 < b0);
        end else begin
          bx_nxt  = a0;
          by_nxt  = b0;
          bx1_nxt = a1;
          dmaj_nxt = a1 - a0;
          yneg_nxt = !(b0 < b1);
        end
        dmin_nxt  = (b1 > b0) ? b1 - b0 : b0 - b1;
        err_nxt   = $signed({2'b00, dmaj_nxt[8:1]});
        state_nxt = S_BR_RD;
      end
      S_BR_RD: begin
        idx_nxt   = pidx(px, py);
        bsel_nxt  = py[2:0];
        rd_en     = 1'b1;
        rd_addr   = idx_nxt;
        state_nxt = S_BR_WR;
      end
      S_BR_WR: begin
        wr_en = 1'b1;
        if (e1 < 0) begin
          by_nxt  = yneg_r ? by_r - 9'd1 : by_r + 9'd1;
          err_nxt = e1 + $signed({1'b0, dmaj_r});
        end else begin
          err_nxt = e1;
        end
        if (bx_r == bx1_r) begin
          ov_nxt    = 1'b1;
          ols_nxt   = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          bx_nxt    = bx_r + 9'd1;
          state_nxt = S_BR_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // frame store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      clr_r   <= '0;
      ov_r    <= 1'b0;
      orb_r   <= 8'd0;
      ops_r   <= 1'b0;
      ols_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
      orb_r   <= orb_nxt;
      ops_r   <= ops_nxt;
      ols_r   <= ols_nxt;
    end
    mode_r  <= mode_nxt;
    bsel_r  <= bsel_nxt;
    idx_r   <= idx_nxt;
    x0_r    <= x0_nxt;
    y0_r    <= y0_nxt;
    x1_r    <= x1_nxt;
    y1_r    <= y1_nxt;
    guard_r <= guard_nxt;
    mula_r  <= mula_nxt;
    mulb_r  <= mulb_nxt;
    den_r   <= den_nxt;
    fix_r   <= fix_nxt;
    vert_r  <= vert_nxt;
    end0_r  <= end0_nxt;
    prod_r  <= prod_nxt;
    bx_r    <= bx_nxt;
    by_r    <= by_nxt;
    bx1_r   <= bx1_nxt;
    dmaj_r  <= dmaj_nxt;
    dmin_r  <= dmin_nxt;
    err_r   <= err_nxt;
    steep_r <= steep_nxt;
    yneg_r  <= yneg_nxt;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/clfe_checker.sv =====
// port-level checks for the engine and their binding
`timescale 1ns / 1ps
`default_nettype none
module clfe_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       busy,
  input wire logic       out_valid,
  input wire logic [7:0] out_read_byte,
  input wire logic       out_pixel_set,
  input wire logic       out_line_shown
);

  // reset starts the store sweep, so no word is taken right after it
  a_busy_after_reset: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low after reset");

  // no result while or right after reset
  a_no_result_in_reset: assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("result during reset");

  // result fields are zero between results
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> (out_read_byte == 8'd0 && !out_pixel_set && !out_line_shown))
    else $error("result fields not zero while idle");

  // a line result never carries read data
  a_line_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_line_shown |-> (out_read_byte == 8'd0 && !out_pixel_set))
    else $error("line result mixed with read data");

endmodule

bind clipped_line_framebuffer_engine clfe_checker u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_read_byte  (out_read_byte),
  .out_pixel_set  (out_pixel_set),
  .out_line_shown (out_line_shown)
);
`default_nettype wire

// ===== tb/clipped_line_framebuffer_engine_tb.sv =====
// self-checking testbench for the clipped line frame store engine
`timescale 1ns / 1ps
module clipped_line_framebuffer_engine_tb;
  import clfe_pkg::*;

  localparam int WIDTH  = 128;
  localparam int HEIGHT = 64;
  localparam int STORE  = WIDTH * ((HEIGHT + 7) / 8);

  // one expected result word
  typedef struct {
    logic [7:0] rd_byte;
    logic       pix;
    logic       shown;
  } answer_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [2:0]         in_command;
  logic signed [15:0] in_start_x;
  logic signed [15:0] in_start_y;
  logic signed [15:0] in_end_x;
  logic signed [15:0] in_end_y;
  logic [1:0]         in_draw_mode;
  logic [9:0]         in_byte_address;
  logic               out_valid;
  logic [7:0]         out_read_byte;
  logic               out_pixel_set;
  logic               out_line_shown;

  // private copy of the frame store and queue of answers still due
  logic [7:0] shadow_store [STORE];
  answer_t    answers_due [$];
  int         mismatches;
  bit         gaps_on;

  clipped_line_framebuffer_engine #(
    .SCREEN_WIDTH (WIDTH),
    .SCREEN_HEIGHT(HEIGHT)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_end_x       (in_end_x),
    .in_end_y       (in_end_y),
    .in_draw_mode   (in_draw_mode),
    .in_byte_address(in_byte_address),
    .out_valid      (out_valid),
    .out_read_byte  (out_read_byte),
    .out_pixel_set  (out_pixel_set),
    .out_line_shown (out_line_shown)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------- predictor ----------------

  function automatic bit in_view(int x, int y);
    return x >= 0 && x < WIDTH && y >= 0 && y < HEIGHT;
  endfunction

  // write one pixel into the shadow store; off-screen pixels and mode 3 do nothing
  function automatic void plot(int x, int y, logic [1:0] m);
    int  idx;
    logic [7:0] bitm;
    if (!in_view(x, y)) return;
    idx  = x + (y >> 3) * WIDTH;
    bitm = 8'd1 << (y & 7);
    case (m)
      MODE_SET: shadow_store[idx] = shadow_store[idx] | bitm;
      MODE_CLR: shadow_store[idx] = shadow_store[idx] & ~bitm;
      MODE_INV: shadow_store[idx] = shadow_store[idx] ^ bitm;
      default: ;
    endcase
  endfunction

  function automatic logic [3:0] region(int x, int y);
    logic [3:0] c;
    c = '0;
    if (x < 0) c |= OC_LEFT;
    else if (x >= WIDTH) c |= OC_RIGHT;
    if (y < 0) c |= OC_TOP;
    else if (y >= HEIGHT) c |= OC_BOTTOM;
    return c;
  endfunction

  // cohen-sutherland against the screen, 64-bit intermediates, truncating division
  function automatic bit clip_segment(inout int x0, inout int y0, inout int x1, inout int y1);
    logic [3:0] c0, c1, co;
    longint     dx, dy, num, den;
    int         nx, ny;
    c0 = region(x0, y0);
    c1 = region(x1, y1);
    for (int guard = 0; guard < 32; guard++) begin
      if ((c0 | c1) == 4'd0) return 1'b1;
      if ((c0 & c1) != 4'd0) return 1'b0;
      co = (c0 != 4'd0) ? c0 : c1;
      dx = longint'(x1) - x0;
      dy = longint'(y1) - y0;
      if ((co & (OC_BOTTOM | OC_TOP)) != 4'd0) begin
        ny  = ((co & OC_BOTTOM) != 4'd0) ? HEIGHT - 1 : 0;
        num = dx * (longint'(ny) - y0);
        den = dy;
        if (den == 0) return 1'b0;
        nx = int'(x0 + num / den);
      end else begin
        nx  = ((co & OC_RIGHT) != 4'd0) ? WIDTH - 1 : 0;
        num = dy * (longint'(nx) - x0);
        den = dx;
        if (den == 0) return 1'b0;
        ny = int'(y0 + num / den);
      end
      if (co == c0) begin
        x0 = nx; y0 = ny; c0 = region(nx, ny);
      end else begin
        x1 = nx; y1 = ny; c1 = region(nx, ny);
      end
    end
    return 1'b0;
  endfunction

  // bresenham from the lower major coordinate, error starting at half the major delta
  function automatic bit trace_line(int x0, int y0, int x1, int y1, logic [1:0] m);
    bit steep;
    int t, dmaj, dmin, err, ystep;
    if (!clip_segment(x0, y0, x1, y1)) return 1'b0;
    steep = ((y1 > y0) ? y1 - y0 : y0 - y1) > ((x1 > x0) ? x1 - x0 : x0 - x1);
    if (steep) begin
      t = x0; x0 = y0; y0 = t;
      t = x1; x1 = y1; y1 = t;
    end
    if (x0 > x1) begin
      t = x0; x0 = x1; x1 = t;
      t = y0; y0 = y1; y1 = t;
    end
    dmaj  = x1 - x0;
    dmin  = (y1 > y0) ? y1 - y0 : y0 - y1;
    err   = dmaj / 2;
    ystep = (y0 < y1) ? 1 : -1;
    for (; x0 <= x1; x0++) begin
      if (steep) plot(y0, x0, m);
      else plot(x0, y0, m);
      err -= dmin;
      if (err < 0) begin
        y0  += ystep;
        err += dmaj;
      end
    end
    return 1'b1;
  endfunction

  // works out the answer of one accepted word and updates the shadow store
  function automatic answer_t execute_word(logic [2:0] cmd, int sx, int sy, int ex, int ey,
                                           logic [1:0] m, logic [9:0] addr);
    answer_t a;
    a = '{8'd0, 1'b0, 1'b0};
    case (cmd)
      CMD_PIXEL: plot(sx, sy, m);
      CMD_LINE: a.shown = trace_line(sx, sy, ex, ey, m);
      CMD_RDPIX:
        if (in_view(sx, sy)) a.pix = shadow_store[sx + (sy >> 3) * WIDTH][sy & 7];
      CMD_RDBYTE:
        if (int'(addr) < STORE) a.rd_byte = shadow_store[addr];
      CMD_CLEAR:
        foreach (shadow_store[i]) shadow_store[i] = 8'd0;
      default: ;
    endcase
    return a;
  endfunction

  // ---------------- driving ----------------

  // present one word at the falling edge and hold it until accepted
  task automatic send_word(logic [2:0] cmd, logic signed [15:0] sx, logic signed [15:0] sy,
                           logic signed [15:0] ex, logic signed [15:0] ey,
                           logic [1:0] m, logic [9:0] addr);
    @(negedge clk);
    in_command      = cmd;
    in_start_x      = sx;
    in_start_y      = sy;
    in_end_x        = ex;
    in_end_y        = ey;
    in_draw_mode    = m;
    in_byte_address = addr;
    start           = 1'b1;
    // busy read here is its value just before the edge
    do @(posedge clk); while (busy);
    answers_due.push_back(execute_word(cmd, sx, sy, ex, ey, m, addr));
    if (gaps_on && $urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 18));
  endtask

  task automatic idle_gap(int n);
    @(negedge clk);
    start = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // sender holds off until every due answer has come back
  task automatic drain();
    idle_gap(1);
    while (answers_due.size() != 0) @(posedge clk);
  endtask

  // ---------------- result checking ----------------

  always @(posedge clk) begin
    answer_t a;
    if (rst_n && out_valid) begin
      if (answers_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word at %0t", $time);
      end else begin
        a = answers_due.pop_front();
        if (out_read_byte !== a.rd_byte || out_pixel_set !== a.pix ||
            out_line_shown !== a.shown) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: read_byte %h/%h pixel_set %b/%b line_shown %b/%b",
                     $time, a.rd_byte, out_read_byte, a.pix, out_pixel_set,
                     a.shown, out_line_shown);
        end
      end
    end
  end

  // ---------------- random word helpers ----------------

  function automatic logic signed [15:0] near_x();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(0, 259)) - 60);
  endfunction

  function automatic logic signed [15:0] near_y();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(0, 159)) - 40);
  endfunction

  task automatic random_word(bit allow_clear);
    int         pick;
    logic [2:0] cmd;
    pick = $urandom_range(0, 99);
    if (pick < 30) cmd = CMD_PIXEL;
    else if (pick < 55) cmd = CMD_LINE;
    else if (pick < 75) cmd = CMD_RDPIX;
    else if (pick < 93) cmd = CMD_RDBYTE;
    else if (pick < 95 && allow_clear) cmd = CMD_CLEAR;
    else cmd = 3'($urandom_range(5, 7));
    send_word(cmd, near_x(), near_y(), near_x(), near_y(),
              2'($urandom_range(0, 3)), 10'($urandom));
  endtask

  // ---------------- tests ----------------

  // store must read back zero after the reset sweep
  task automatic test_reset_state();
    send_word(CMD_RDBYTE, 0, 0, 0, 0, MODE_SET, 10'd0);
    send_word(CMD_RDBYTE, 0, 0, 0, 0, MODE_SET, 10'd1023);
    send_word(CMD_RDPIX, 127, 63, 0, 0, MODE_SET, 10'd0);
  endtask

  // corners, off-screen pixels, every mode, the special lines and commands
  task automatic test_directed();
    send_word(CMD_PIXEL, 0, 0, 0, 0, MODE_SET, 10'd0);
    send_word(CMD_PIXEL, 127, 63, 0, 0, MODE_SET, 10'd0);
    send_word(CMD_PIXEL, -1, 5, 0, 0, MODE_SET, 10'd0);
    send_word(CMD_PIXEL, 128, 64, 0, 0, MODE_SET, 10'd0);
    send_word(CMD_PIXEL, 0, 0, 0, 0, MODE_INV, 10'd0);
    send_word(CMD_PIXEL, 127, 63, 0, 0, MODE_CLR, 10'd0);
    send_word(CMD_PIXEL, 3, 3, 0, 0, 2'd3, 10'd0);         // unused mode
    send_word(CMD_RDPIX, -32768, 32767, 0, 0, MODE_SET, 10'd0);
    send_word(CMD_RDBYTE, 0, 0, 0, 0, MODE_SET, 10'h3ff);
    send_word(CMD_LINE, 0, 10, 127, 10, MODE_SET, 10'd0);   // horizontal
    send_word(CMD_LINE, 5, 0, 5, 63, MODE_SET, 10'd0);      // vertical
    send_word(CMD_LINE, 100, 60, 90, 2, MODE_INV, 10'd0);   // steep, reversed
    send_word(CMD_LINE, -50, -50, -10, -20, MODE_SET, 10'd0); // rejected
    send_word(CMD_LINE, -32768, -32768, 32767, 32767, MODE_SET, 10'd0);
    send_word(CMD_LINE, 32767, -32768, -32768, 32767, MODE_CLR, 10'd0);
    send_word(CMD_LINE, -20, 30, 200, 31, MODE_INV, 10'd0); // clipped both ends
    send_word(CMD_LINE, 7, 7, 7, 7, MODE_SET, 10'd0);       // single point
    send_word(CMD_RDBYTE, 0, 0, 0, 0, MODE_SET, 10'd133);
    send_word(CMD_RDPIX, 5, 40, 0, 0, MODE_SET, 10'd0);
    send_word(3'd7, 16'h7fff, 16'h8000, 16'hffff, 16'h5555, 2'd3, 10'h2aa); // unused
    send_word(CMD_CLEAR, 0, 0, 0, 0, MODE_SET, 10'd0);
    send_word(CMD_RDBYTE, 0, 0, 0, 0, MODE_SET, 10'd266);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) random_word(1'b1);
  endtask

  // back to back words with no gaps, clear kept out to stay short
  task automatic test_back_to_back(int n);
    gaps_on = 1'b0;
    for (int i = 0; i < n; i++) random_word(1'b0);
  endtask

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_command      = CMD_PIXEL;
    in_start_x      = '0;
    in_start_y      = '0;
    in_end_x        = '0;
    in_end_y        = '0;
    in_draw_mode    = MODE_SET;
    in_byte_address = '0;
    mismatches      = 0;
    gaps_on         = 1'b1;
    foreach (shadow_store[i]) shadow_store[i] = 8'd0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_directed();
    test_random(500);
    drain();
    test_random(400);
    test_back_to_back(150);

    // final drain plus a settling margin
    idle_gap(1);
    while (answers_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && answers_due.size() == 0)
      $display("clipped_line_framebuffer_engine_tb OK");
    else
      $display("clipped_line_framebuffer_engine_tb NOT OK");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("clipped_line_framebuffer_engine_tb NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/clfe_pkg.sv
hw/rtl/clfe_front.sv
hw/rtl/clfe_div.sv
hw/rtl/clfe_back.sv
hw/rtl/clipped_line_framebuffer_engine.sv
hw/rtl/clfe_checker.sv
tb/clipped_line_framebuffer_engine_tb.sv
